// ----- sv/utf8d_pkg.sv -----
`default_nettype none
package utf8d_pkg;

  // code point limits and rejected ranges
  localparam logic [20:0] CP_MAX    = 21'h10FFFF;
  localparam logic [20:0] SURR_LO   = 21'h00D800;
  localparam logic [20:0] SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] NONCH_LO  = 21'h00FDD0;
  localparam logic [20:0] NONCH_HI  = 21'h00FDEF;
  localparam logic [15:0] PLANE_END = 16'hFFFE;

  // continuation byte tag
  localparam logic [1:0] CONT_TAG = 2'b10;

  // one decoded item
  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  byte_count;
    logic        error;
  } res_t;

  // decoder sequence state
  typedef struct packed {
    logic [20:0] partial_value;
    logic [1:0]  bytes_remaining;
    logic [2:0]  sequence_length;
  } seq_t;

  // sequence length from a lead byte, zero for an invalid lead
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] n;
    if (b == 8'h00)       n = 3'd0;
    else if (b < 8'h80)   n = 3'd1;
    else if (b < 8'hC2)   n = 3'd0;
    else if (b < 8'hE0)   n = 3'd2;
    else if (b < 8'hF0)   n = 3'd3;
    else if (b < 8'hF5)   n = 3'd4;
    else                  n = 3'd0;
    return n;
  endfunction

  // value bits kept from a lead byte of the given length
  function automatic logic [7:0] lead_keep(input logic [2:0] n);
    logic [7:0] m;
    unique case (n)
      3'd1:    m = 8'h7F;
      3'd2:    m = 8'h1F;
      3'd3:    m = 8'h0F;
      3'd4:    m = 8'h07;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // true when a finished code point is rejected
  function automatic logic cp_bad(input logic [20:0] v);
    logic bad;
    bad = (v > CP_MAX)
       || ((v >= SURR_LO) && (v <= SURR_HI))
       || ((v >= NONCH_LO) && (v <= NONCH_HI))
       || ((v[15:0] & PLANE_END) == PLANE_END);
    return bad;
  endfunction

endpackage
`default_nettype wire

// ----- sv/utf8_validating_decoder_top.sv -----
`default_nettype none
// UTF-8 validating decoder
// input channel: one raw stream byte per item on in_byte (in_valid / in_stall)
// result channel: one item per finished character or error, carrying
//   out_code_point, out_byte_count and out_error (out_valid / out_stall)
// lead and middle bytes of a sequence give no result; the final byte, an
//   invalid lead, a missing continuation or a rejected code point give one
// throughput: one byte per cycle while in_stall is low, set by the single decode step between the
//   sequence state register and the output register
// output: a result from its last byte is registered in the output register, or in the skid register while held
// stall: a result held by out_stall keeps its payload; one more result is
//   caught in a skid register, and in_stall rises only while that is full
// reset (rst_n low, synchronous): sequence state cleared to awaiting a lead
//   byte, output and skid registers emptied
module utf8_validating_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [20:0]      out_code_point,
  output logic [2:0]       out_byte_count,
  output logic             out_error
);
  import utf8d_pkg::*;

  seq_t seq_r;
  seq_t seq_nxt;
  logic res_valid;
  res_t res;
  logic in_acc;
  logic out_free;

  logic out_valid_r;
  res_t out_r;
  logic skid_valid_r;
  res_t skid_r;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  utf8d_step u_step (
    .byte_i      (in_byte),
    .seq_i       (seq_r),
    .seq_o       (seq_nxt),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
    end else if (in_acc) begin
      seq_r <= seq_nxt;
    end
  end

  // output register and skid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc && res_valid;
      end
    end else if (in_acc && res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) out_r <= skid_r;
      else              out_r <= res;
    end else if (in_acc && res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_r.code_point;
  assign out_byte_count = out_r.byte_count;
  assign out_error      = out_r.error;

endmodule
`default_nettype wire

// ----- sv/utf8d_step.sv -----
`default_nettype none
module utf8d_step (
  input  wire logic [7:0]     byte_i,
  input  utf8d_pkg::seq_t     seq_i,
  output utf8d_pkg::seq_t     seq_o,
  output logic                res_valid_o,
  output utf8d_pkg::res_t     res_o
);
  import utf8d_pkg::*;

  logic [2:0]  n;
  logic [20:0] lead_v;
  logic [20:0] cont_v;
  logic [1:0]  rem_dec;
  logic [20:0] fin_v;
  logic [2:0]  fin_cnt;
  logic        fin;
  logic        fail;

  assign n       = lead_length(byte_i);
  assign lead_v  = {13'd0, byte_i & lead_keep(n)};
  assign cont_v  = {seq_i.partial_value[14:0], byte_i[5:0]};
  assign rem_dec = seq_i.bytes_remaining - 2'd1;

  // one decode step for the accepted byte
  always_comb begin
    seq_o   = seq_i;
    fin     = 1'b0;
    fail    = 1'b0;
    fin_v   = lead_v;
    fin_cnt = 3'd1;
    if (seq_i.bytes_remaining == 2'd0) begin
      if (n == 3'd0) begin
        fail = 1'b1;
      end else if (n == 3'd1) begin
        fin = 1'b1;
      end else begin
        seq_o.partial_value   = lead_v;
        seq_o.sequence_length = n;
        seq_o.bytes_remaining = n[1:0] - 2'd1;
      end
    end else if (byte_i[7:6] != CONT_TAG) begin
      fail = 1'b1;
    end else begin
      seq_o.partial_value   = cont_v;
      seq_o.bytes_remaining = rem_dec;
      if (rem_dec == 2'd0) begin
        fin     = 1'b1;
        fin_v   = cont_v;
        fin_cnt = seq_i.sequence_length;
      end
    end
    if (fin && cp_bad(fin_v)) fail = 1'b1;
    // any result returns to awaiting a lead byte
    if (fin || fail) seq_o = '0;
    res_valid_o = fin || fail;
    if (fail) res_o = '{code_point: 21'd0, byte_count: 3'd0, error: 1'b1};
    else      res_o = '{code_point: fin_v, byte_count: fin_cnt, error: 1'b0};
  end

endmodule
`default_nettype wire

// ----- sim/tb_utf8_validating_decoder_top.sv -----
`default_nettype none
module tb_utf8_validating_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8d_pkg::*;

  localparam int N_DIR      = 25;
  localparam int RAND_BYTES = 1150;
  localparam int IDLE_LIMIT = 2000;

  // one byte of the stream, with a typed-in expected char where one is given
  typedef struct packed {
    logic [7:0]  data;
    logic        typed;
    logic [20:0] cp;
    logic [2:0]  cnt;
    logic        err;
  } byte_item_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [20:0] out_code_point;
  logic [2:0]  out_byte_count;
  logic        out_error;

  utf8_validating_decoder_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_byte_count (out_byte_count),
    .out_error      (out_error)
  );

  always #2 clk = ~clk;

  // directed rows: single bytes (invalid leads and one-byte extremes), then multi-byte cases
  byte_item_t dir_tab [0:N_DIR-1] = '{
    '{8'h00, 1'b1, 21'h0, 3'd0, 1'b1},
    '{8'h01, 1'b1, 21'h1, 3'd1, 1'b0},
    '{8'h7F, 1'b1, 21'h7F, 3'd1, 1'b0},
    '{8'h80, 1'b1, 21'h0, 3'd0, 1'b1},
    '{8'hC0, 1'b1, 21'h0, 3'd0, 1'b1},
    '{8'hC1, 1'b1, 21'h0, 3'd0, 1'b1},
    '{8'hF5, 1'b1, 21'h0, 3'd0, 1'b1},
    '{8'hFF, 1'b1, 21'h0, 3'd0, 1'b1},
    // largest two-byte char
    '{8'hDF, 1'b0, 21'h0, 3'd0, 1'b0},
    '{8'hBF, 1'b1, 21'h7FF, 3'd2, 1'b0},
    // surrogate
    '{8'hED, 1'b0, 21'h0, 3'd0, 1'b0},
    '{8'hA0, 1'b0, 21'h0, 3'd0, 1'b0},
    '{8'h80, 1'b1, 21'h0, 3'd0, 1'b1},
    // noncharacter block
    '{8'hEF, 1'b0, 21'h0, 3'd0, 1'b0},
    '{8'hB7, 1'b0, 21'h0, 3'd0, 1'b0},
    '{8'h90, 1'b1, 21'h0, 3'd0, 1'b1},
    // plane-end noncharacter
    '{8'hEF, 1'b0, 21'h0, 3'd0, 1'b0},
    '{8'hBF, 1'b0, 21'h0, 3'd0, 1'b0},
    '{8'hBE, 1'b1, 21'h0, 3'd0, 1'b1},
    // missing continuation, the ascii byte is swallowed
    '{8'hC2, 1'b0, 21'h0, 3'd0, 1'b0},
    '{8'h41, 1'b1, 21'h0, 3'd0, 1'b1},
    // above the last code point
    '{8'hF4, 1'b0, 21'h0, 3'd0, 1'b0},
    '{8'h90, 1'b0, 21'h0, 3'd0, 1'b0},
    '{8'h80, 1'b0, 21'h0, 3'd0, 1'b0},
    '{8'h80, 1'b1, 21'h0, 3'd0, 1'b1}
  };

  byte_item_t stream_q[$];
  res_t       char_q[$];
  int         mismatches = 0;
  int         idle_cycles = 0;

  // decoder state mirror
  logic [20:0] acc_value  = '0;
  logic [1:0]  conts_left = '0;
  logic [2:0]  seq_bytes  = '0;

  // finished value: either the char or a rejection
  function automatic res_t close_char(input logic [20:0] v, input logic [2:0] cnt);
    res_t r;
    r = '0;
    if (v > CP_MAX || (v >= SURR_LO && v <= SURR_HI) || (v >= NONCH_LO && v <= NONCH_HI)
        || v[15:1] == 15'h7FFF) begin
      r.error = 1'b1;
    end else begin
      r.code_point = v;
      r.byte_count = cnt;
    end
    return r;
  endfunction

  // step the mirror by one byte, returns 1 when a char comes out
  function automatic bit decode_byte(input logic [7:0] b, output res_t r);
    logic [2:0] n;
    bit         done;
    r    = '0;
    done = 1'b0;
    if (conts_left == 2'd0) begin
      // lead byte
      if (b == 8'h00 || (b >= 8'h80 && b <= 8'hC1) || b >= 8'hF5) n = 3'd0;
      else if (b < 8'h80) n = 3'd1;
      else if (b < 8'hE0) n = 3'd2;
      else if (b < 8'hF0) n = 3'd3;
      else n = 3'd4;
      if (n == 3'd0) begin
        r.error = 1'b1;
        done    = 1'b1;
      end else if (n == 3'd1) begin
        r    = close_char({14'd0, b[6:0]}, 3'd1);
        done = 1'b1;
      end else begin
        acc_value  = {13'd0, b & (8'hFF >> (n + 3'd1))};
        seq_bytes  = n;
        conts_left = n[1:0] - 2'd1;
      end
    end else if (b[7:6] != CONT_TAG) begin
      // not a continuation: sequence dies, byte is consumed
      r.error = 1'b1;
      done    = 1'b1;
    end else begin
      acc_value  = {acc_value[14:0], b[5:0]};
      conts_left = conts_left - 2'd1;
      if (conts_left == 2'd0) begin
        r    = close_char(acc_value, seq_bytes);
        done = 1'b1;
      end
    end
    if (done) begin
      acc_value  = '0;
      conts_left = '0;
      seq_bytes  = '0;
    end
    return done;
  endfunction

  // receiver: phases of no stall, random stall and runs of alternating stall and no stall
  int stall_mode = 0;
  int phase_left = 0;
  int run_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        phase_left <= $urandom_range(50, 300);
      end else begin
        phase_left <= phase_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        default: begin
          if (run_left == 0) begin
            out_stall <= ~out_stall;
            run_left  <= $urandom_range(1, 12);
          end else begin
            run_left <= run_left - 1;
          end
        end
      endcase
    end
  end

  // result check against the oldest expected char
  res_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (char_q.size() == 0) begin
        $error("unexpected item: code_point %h byte_count %0d error %0b",
               out_code_point, out_byte_count, out_error);
        mismatches++;
      end else begin
        want = char_q.pop_front();
        if (out_code_point !== want.code_point) begin
          $error("code_point: expected %h, actual %h", want.code_point, out_code_point);
          mismatches++;
        end
        if (out_byte_count !== want.byte_count) begin
          $error("byte_count: expected %0d, actual %0d", want.byte_count, out_byte_count);
          mismatches++;
        end
        if (out_error !== want.error) begin
          $error("error: expected %0b, actual %0b", want.error, out_error);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus build and drive
  initial begin
    byte_item_t item;
    res_t       got;
    bit         has;
    logic [7:0] c;
    int         pick, len, bad_at, k, idx, burst, gap;
    bit         cut;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_byte   = 8'h00;

    for (k = 0; k < N_DIR; k++) stream_q.push_back(dir_tab[k]);

    // random part: mostly well-formed chars, some broken ones and noise
    while (stream_q.size() < N_DIR + RAND_BYTES) begin
      pick = $urandom_range(0, 99);
      item = '0;
      if (pick < 13) begin
        item.data = 8'($urandom_range(0, 255));
        stream_q.push_back(item);
      end else begin
        len = $urandom_range(1, 4);
        case (len)
          1: item.data = 8'($urandom_range(8'h01, 8'h7F));
          2: item.data = 8'($urandom_range(8'hC2, 8'hDF));
          3: item.data = 8'($urandom_range(8'hE0, 8'hEF));
          default: item.data = 8'($urandom_range(8'hF0, 8'hF4));
        endcase
        stream_q.push_back(item);
        bad_at = (pick < 25 && len > 1) ? $urandom_range(1, len - 1) : 0;
        cut    = 1'b0;
        for (k = 1; k < len && !cut; k++) begin
          if (k == bad_at) begin
            // non-continuation byte where one is due
            c = 8'($urandom_range(0, 191));
            if (c >= 8'd128) c = c + 8'd64;
            cut = 1'b1;
          end else if ($urandom_range(0, 5) == 0) begin
            // lean toward the top of the plane
            c = 8'hBE | 8'($urandom_range(0, 1));
          end else begin
            c = 8'h80 | 8'($urandom_range(0, 63));
          end
          item.data = c;
          stream_q.push_back(item);
        end
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender: short and long bursts, each mostly followed by a gap; some bursts have none
    idx = 0;
    while (idx < stream_q.size()) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (k = 0; k < burst && idx < stream_q.size(); k++) begin
        item = stream_q[idx];
        in_valid <= 1'b1;
        in_byte  <= item.data;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        has = decode_byte(item.data, got);
        if (item.typed) begin
          has            = 1'b1;
          got.code_point = item.cp;
          got.byte_count = item.cnt;
          got.error      = item.err;
        end
        if (has) char_q.push_back(got);
        idx++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // drain
    while (char_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- utf8_validating_decoder_top.f -----
sv/utf8d_pkg.sv
sv/utf8d_step.sv
sv/utf8_validating_decoder_top.sv
sim/tb_utf8_validating_decoder_top.sv
